// ===== rtl/core/census_transform_9x7_top_macros.svh =====
// Assertion macros for the census transform block.
`ifndef CENSUS_TRANSFORM_9X7_TOP_MACROS_SVH
`define CENSUS_TRANSFORM_9X7_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CT97_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ct97: implication check failed");
`define CT97_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ct97: next-cycle check failed");
`else
`define CT97_ASSERT_IMP(label, cond, prop)
`define CT97_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ===== rtl/core/ct97_pkg.sv =====
package ct97_pkg;

    localparam int PIX_W          = 8;
    localparam int LINES          = 6;
    localparam int WIN_W          = 9;
    localparam int WIN_H          = 7;
    localparam int WIN_N          = WIN_W * WIN_H;
    localparam int CENTRE_ROW_OFF = 3;
    localparam int CENTRE_COL_OFF = 4;
    localparam int CENTRE_IDX     = CENTRE_ROW_OFF * WIN_W + CENTRE_COL_OFF;
    localparam int DESC_W         = WIN_N - 1;
    localparam int CROW_W         = 12;
    localparam int CCOL_W         = 11;
    localparam int FW_W           = 12;
    localparam int FH_W           = 13;
    localparam int SLOT_W         = 3;
    localparam int MIN_W          = WIN_W;
    localparam int MIN_H          = WIN_H;
    localparam int ODATA_RAW_W    = DESC_W + CROW_W + CCOL_W;
    localparam int ODATA_W        = ((ODATA_RAW_W + 7) / 8) * 8;

    localparam logic [FW_W-1:0] RESET_WIDTH  = 12'd960;
    localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd400;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic              emit;
        logic              last;
        logic [CROW_W-1:0] center_row;
        logic [CCOL_W-1:0] center_col;
        logic [SLOT_W-1:0] slot;
    } pos_t;

endpackage

// ===== rtl/core/ct97_line_mem.sv =====
module ct97_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic [AW-1:0]                              addr,
    input  logic [ct97_pkg::SLOT_W-1:0]                wr_lane,
    input  logic [ct97_pkg::PIX_W-1:0]                 wr_byte,
    output logic [ct97_pkg::LINES*ct97_pkg::PIX_W-1:0] rdata
);
    import ct97_pkg::*;

    logic [LINES*PIX_W-1:0] mem [DEPTH];
    logic [LINES*PIX_W-1:0] rdata_reg;

    // read-first: the row read back is the one stored before this write
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            for (int l = 0; l < LINES; l++)
            begin
                if (wr_lane == SLOT_W'(l))
                begin
                    mem[addr][l*PIX_W +: PIX_W] <= wr_byte;
                end
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ct97_ctrl.sv =====
module ct97_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               frame_start,
    input  logic [ct97_pkg::FW_W-1:0]          frame_width,
    input  logic [ct97_pkg::FH_W-1:0]          frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0]       col,
    output ct97_pkg::pos_t                     pos
);
    import ct97_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int EW    = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
    localparam int EH    = ($clog2(MAX_HEIGHT + 1) > FH_W) ? $clog2(MAX_HEIGHT + 1) : FH_W;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [EW-1:0]     fw_ext, w, col_inc;
    logic [EH-1:0]     fh_ext, h, row_inc;
    logic [COL_W-1:0]  col0, colc;
    logic [ROW_W-1:0]  row0, rowc;
    logic [SLOT_W-1:0] slot0, slotc, slot_inc;

    // saturate the frame size into its usable range
    always_comb
    begin
        fw_ext = EW'(frame_width);
        fh_ext = EH'(frame_height);
        if (fw_ext < EW'(MIN_W))
            w = EW'(MIN_W);
        else if (fw_ext > EW'(MAX_WIDTH))
            w = EW'(MAX_WIDTH);
        else
            w = fw_ext;
        if (fh_ext < EH'(MIN_H))
            h = EH'(MIN_H);
        else if (fh_ext > EH'(MAX_HEIGHT))
            h = EH'(MAX_HEIGHT);
        else
            h = fh_ext;
    end

    // position of this pixel: restart on frame start, wrap past a lowered bound
    always_comb
    begin
        col0  = frame_start ? '0 : col_reg;
        row0  = frame_start ? '0 : row_reg;
        slot0 = frame_start ? '0 : slot_reg;
        colc  = (EW'(col0) >= w) ? '0 : col0;
        rowc  = (EH'(row0) >= h) ? '0 : row0;
        slotc = (EH'(row0) >= h) ? '0 : slot0;
        col_inc  = EW'(colc) + EW'(1);
        row_inc  = EH'(rowc) + EH'(1);
        slot_inc = (slotc == SLOT_W'(LINES - 1)) ? '0 : slotc + SLOT_W'(1);
    end

    assign col            = colc;
    assign pos.emit       = (EH'(rowc) >= EH'(WIN_H - 1)) && (EW'(colc) >= EW'(WIN_W - 1));
    assign pos.last       = (row_inc == h) && (col_inc == w);
    assign pos.center_row = CROW_W'(EH'(rowc) - EH'(CENTRE_ROW_OFF));
    assign pos.center_col = CCOL_W'(EW'(colc) - EW'(CENTRE_COL_OFF));
    assign pos.slot       = slotc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            if (col_inc >= w)
            begin
                col_reg <= '0;
                if (row_inc >= h)
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= ROW_W'(row_inc);
                    slot_reg <= slot_inc;
                end
            end
            else
            begin
                col_reg  <= COL_W'(col_inc);
                row_reg  <= rowc;
                slot_reg <= slotc;
            end
        end
    end

endmodule

// ===== rtl/core/ct97_window.sv =====
module ct97_window (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       shift_en,
    input  logic [ct97_pkg::SLOT_W-1:0]                slot,
    input  logic [ct97_pkg::LINES*ct97_pkg::PIX_W-1:0] rdata,
    input  logic [ct97_pkg::PIX_W-1:0]                 pix,
    output logic [ct97_pkg::DESC_W-1:0]                descriptor
);
    import ct97_pkg::*;

    logic [PIX_W-1:0]  win_reg [WIN_N];
    logic [PIX_W-1:0]  lanes   [LINES];
    logic [PIX_W-1:0]  column  [WIN_H];
    logic [SLOT_W:0]   lane_sum;
    logic [SLOT_W-1:0] lane_sel;

    // line store lane (slot + r) mod 6 holds the row six above, then downwards
    always_comb
    begin
        lane_sum = '0;
        lane_sel = '0;
        for (int l = 0; l < LINES; l++)
        begin
            lanes[l] = rdata[l*PIX_W +: PIX_W];
        end
        for (int r = 0; r < LINES; r++)
        begin
            lane_sum = {1'b0, slot} + (SLOT_W+1)'(r);
            if (lane_sum >= (SLOT_W+1)'(LINES))
                lane_sel = SLOT_W'(lane_sum - (SLOT_W+1)'(LINES));
            else
                lane_sel = SLOT_W'(lane_sum);
            column[r] = lanes[lane_sel];
        end
        column[WIN_H-1] = pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_N; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int r = 0; r < WIN_H; r++)
            begin
                for (int k = 0; k < WIN_W - 1; k++)
                begin
                    win_reg[r*WIN_W + k] <= win_reg[r*WIN_W + k + 1];
                end
                win_reg[r*WIN_W + WIN_W - 1] <= column[r];
            end
        end
    end

    // one bit per neighbour strictly darker than the centre, centre skipped
    always_comb
    begin
        descriptor = '0;
        for (int i = 0; i < WIN_N; i++)
        begin
            if (i < CENTRE_IDX)
                descriptor[i] = win_reg[i] < win_reg[CENTRE_IDX];
            else if (i > CENTRE_IDX)
                descriptor[i-1] = win_reg[i] < win_reg[CENTRE_IDX];
        end
    end

endmodule

// ===== rtl/core/census_transform_9x7_top.sv =====
// 9x7 census transform over a raster-order 8-bit pixel stream.
// Input stream: tdata carries one pixel, tuser flags the first pixel of a frame.
// Output stream: one transaction per centre pixel at least 3 rows and 4 columns
// from every border; tdata holds descriptor, centre row and centre column,
// tlast marks the final descriptor of the frame. Border pixels give nothing.
// Frame size is set through the write port (index 0 width, 1 height); the user
// must write it only while idle, as the block itself does not enforce this.
// Throughput: 1 pixel per clock unless stalled, set by the line memory, which
// is read (six rows in one word) and written (one byte lane) once per pixel.
// Reset: position counters go to zero, frame size to 960 x 400, pipeline empties;
// the line memory is not cleared and needs no clearing pass.
// Stall: while a result waits, border pixels keep flowing; tready drops once the
// next descriptor's pixel waits in stage 2 with one more pixel held in stage 1.
`include "census_transform_9x7_top_macros.svh"

module census_transform_9x7_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [ct97_pkg::FH_W-1:0]         cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ct97_pkg::PIX_W-1:0]        s_axis_tdata,  // [7:0] pixel_value
    input  logic                              s_axis_tuser,  // [0] frame_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [61:0] descriptor, [73:62] center_row, [84:74] center_col, rest zero
    output logic [ct97_pkg::ODATA_W-1:0]      m_axis_tdata,
    output logic                              m_axis_tlast   // frame_last
);
    import ct97_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [FW_W-1:0]        width_reg;
    logic [FH_W-1:0]        height_reg;

    logic                   accept;
    logic [COL_W-1:0]       col;
    pos_t                   pos;
    logic [LINES*PIX_W-1:0] rdata;
    logic [DESC_W-1:0]      descriptor;

    logic                   s1_valid_reg;
    pos_t                   s1_pos_reg;
    logic [PIX_W-1:0]       s1_pix_reg;
    logic                   s2_valid_reg;
    pos_t                   s2_pos_reg;
    logic                   out_valid_reg;
    logic [ODATA_W-1:0]     out_data_reg;
    logic                   out_last_reg;

    logic                   out_free, s2_free, s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // border items leave stage 2 without needing the output register
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s2_free       = !s2_valid_reg || !s2_pos_reg.emit || out_free;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign s_axis_tready = s1_free;
    assign accept        = s_axis_tvalid && s1_free;

    ct97_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (s_axis_tuser),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .col          (col),
        .pos          (pos)
    );

    ct97_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .en      (accept),
        .addr    (col),
        .wr_lane (pos.slot),
        .wr_byte (s_axis_tdata),
        .rdata   (rdata)
    );

    ct97_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (s1_valid_reg && s2_free),
        .slot       (s1_pos_reg.slot),
        .rdata      (rdata),
        .pix        (s1_pix_reg),
        .descriptor (descriptor)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg && s2_pos_reg.emit && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= pos;
            s1_pix_reg <= s_axis_tdata;
        end
        if (s2_free)
            s2_pos_reg <= s1_pos_reg;
        if (s2_valid_reg && s2_pos_reg.emit && out_free)
        begin
            out_data_reg <= ODATA_W'({s2_pos_reg.center_col, s2_pos_reg.center_row, descriptor});
            out_last_reg <= s2_pos_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `CT97_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready,
        s1_valid_reg && s2_valid_reg && s2_pos_reg.emit && out_valid_reg && !m_axis_tready)
    `CT97_ASSERT_NEXT(a_frame_start_no_result, accept && s_axis_tuser, !s1_pos_reg.emit)
    `CT97_ASSERT_NEXT(a_result_loaded, s2_valid_reg && s2_pos_reg.emit && out_free,
        m_axis_tvalid)

endmodule

// ===== dv/tb_census_transform_9x7_top.sv =====
module tb_census_transform_9x7_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ct97_pkg::*;

    localparam int MAX_W = 2048;
    localparam int MAX_H = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 4000;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        PAT_RANDOM,
        PAT_BAND,
        PAT_EXTREME,
        PAT_CENTRE_MAX,
        PAT_CENTRE_MIN,
        PAT_FLAT,
        PAT_NEAR,
        PAT_MIXED
    } pixel_pattern_t;

    typedef struct packed {
        logic              last;
        logic [CCOL_W-1:0] col;
        logic [CROW_W-1:0] row;
        logic [DESC_W-1:0] census;
    } descriptor_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_addr;
    logic [FH_W-1:0]     cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [PIX_W-1:0]    s_axis_tdata;   // [7:0] pixel_value
    logic                s_axis_tuser;   // [0] frame_start
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [61:0] descriptor, [73:62] center_row, [84:74] center_col, rest zero
    logic [ODATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;   // frame_last

    bit                  idle_on;
    int unsigned         cycle_count;
    int unsigned         pixels_in;
    int unsigned         settings_used;

    census_transform_9x7_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic int unsigned clamp_width(logic [FW_W-1:0] raw);
        if (raw < MIN_W)
            return MIN_W;
        if (raw > MAX_W)
            return MAX_W;
        return 32'(raw);
    endfunction

    function automatic int unsigned clamp_height(logic [FH_W-1:0] raw);
        if (raw < MIN_H)
            return MIN_H;
        if (raw > MAX_H)
            return MAX_H;
        return 32'(raw);
    endfunction

    class census_checker;
        logic [PIX_W-1:0] line_mem [LINES*MAX_W];
        logic [PIX_W-1:0] win [WIN_H][WIN_W];
        int unsigned      row_pos;
        int unsigned      col_pos;
        logic [FW_W-1:0]  width_reg;
        logic [FH_W-1:0]  height_reg;
        descriptor_t      pending_descriptors[$];
        int unsigned      checked;
        int unsigned      faults;

        function new();
            foreach (line_mem[i])
                line_mem[i] = '0;
            foreach (win[r, k])
                win[r][k] = '0;
            row_pos = 0;
            col_pos = 0;
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            checked = 0;
            faults = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [FH_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg = value[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg = value;
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic first);
            int unsigned      w;
            int unsigned      h;
            int unsigned      n;
            logic [PIX_W-1:0] column [WIN_H];
            logic [PIX_W-1:0] centre;
            descriptor_t      d;
            w = clamp_width(width_reg);
            h = clamp_height(height_reg);
            if (first)
            begin
                row_pos = 0;
                col_pos = 0;
            end
            if (col_pos >= w)
                col_pos = 0;
            if (row_pos >= h)
                row_pos = 0;
            // slot (row + r) % LINES holds row (row - LINES + r)
            for (int r = 0; r < LINES; r++)
                column[r] = line_mem[((row_pos + r) % LINES) * MAX_W + col_pos];
            column[LINES] = pix;
            line_mem[(row_pos % LINES) * MAX_W + col_pos] = pix;
            for (int r = 0; r < WIN_H; r++)
            begin
                for (int k = 0; k < WIN_W - 1; k++)
                    win[r][k] = win[r][k+1];
                win[r][WIN_W-1] = column[r];
            end
            if (row_pos >= WIN_H - 1 && col_pos >= WIN_W - 1)
            begin
                centre = win[CENTRE_ROW_OFF][CENTRE_COL_OFF];
                d = '0;
                n = 0;
                for (int r = 0; r < WIN_H; r++)
                    for (int k = 0; k < WIN_W; k++)
                        if (!(r == CENTRE_ROW_OFF && k == CENTRE_COL_OFF))
                        begin
                            d.census[n] = (win[r][k] < centre);
                            n++;
                        end
                d.row = CROW_W'(row_pos - CENTRE_ROW_OFF);
                d.col = CCOL_W'(col_pos - CENTRE_COL_OFF);
                d.last = (row_pos + 1 == h) && (col_pos + 1 == w);
                pending_descriptors.push_back(d);
            end
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        function void check_descriptor(logic [ODATA_W-1:0] data, logic last);
            descriptor_t got;
            descriptor_t want;
            got.census = data[DESC_W-1:0];
            got.row = data[DESC_W +: CROW_W];
            got.col = data[DESC_W+CROW_W +: CCOL_W];
            got.last = last;
            if (pending_descriptors.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("ERROR: unexpected descriptor census=%h row=%0d col=%0d last=%b",
                             got.census, got.row, got.col, got.last);
                return;
            end
            want = pending_descriptors.pop_front();
            checked++;
            if (got.census !== want.census || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                begin
                    $display("ERROR: descriptor %0d mismatch", checked);
                    $display("  expected census=%h row=%0d col=%0d last=%b",
                             want.census, want.row, want.col, want.last);
                    $display("  actual   census=%h row=%0d col=%0d last=%b",
                             got.census, got.row, got.col, got.last);
                end
            end
        endfunction
    endclass

    census_checker sb;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("census_transform_9x7_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_idx_t'(cfg_addr), cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_pixel(s_axis_tdata, s_axis_tuser);
                pixels_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_descriptor(m_axis_tdata, m_axis_tlast);
        end
    end

    initial
    begin : result_sink
        int unsigned hold;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (!idle_on)
                m_axis_tready <= 1'b1;
            else
                case ($urandom_range(0, 9))
                    0:
                    begin
                        m_axis_tready <= 1'b0;
                        hold = $urandom_range(10, 60);
                    end
                    1, 2, 3:
                    begin
                        m_axis_tready <= 1'b0;
                        hold = $urandom_range(1, 3);
                    end
                    default:
                    begin
                        m_axis_tready <= 1'b1;
                        hold = $urandom_range(0, 20);
                    end
                endcase
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = 0;
        if (idle_on)
            case ($urandom_range(0, 19))
                0:          n = $urandom_range(8, 30);
                1, 2, 3, 4: n = $urandom_range(1, 3);
                default:    n = 0;
            endcase
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // wait for outstanding descriptors, then let border pixels clear the pipe
    task automatic drain();
        int unsigned waited;
        waited = 0;
        while (sb.pending_descriptors.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_frame_size(input logic [FH_W-1:0] w_raw, input logic [FH_W-1:0] h_raw);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_FRAME_WIDTH;
        cfg_wdata <= w_raw;
        @(negedge clk);
        cfg_addr <= CFG_FRAME_HEIGHT;
        cfg_wdata <= h_raw;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic run_phase(input logic [FH_W-1:0] w_raw, input logic [FH_W-1:0] h_raw,
                             input bit write_cfg, input int unsigned count, input bit resume,
                             input bit noisy, input pixel_pattern_t pattern,
                             input int unsigned hold_at);
        int unsigned      w;
        int unsigned      h;
        int unsigned      frame_len;
        int unsigned      r;
        int unsigned      c;
        int unsigned      base;
        pixel_pattern_t   pat;
        logic [PIX_W-1:0] pix;
        logic             first;
        if (write_cfg)
            write_frame_size(w_raw, h_raw);
        w = write_cfg ? clamp_width(w_raw[FW_W-1:0]) : clamp_width(sb.width_reg);
        h = write_cfg ? clamp_height(h_raw) : clamp_height(sb.height_reg);
        frame_len = w * h;
        pat = pattern;
        base = 128;
        for (int unsigned pos = 0; pos < count; pos++)
        begin
            first = 1'b0;
            if (pos % frame_len == 0)
            begin
                base = $urandom_range(2, 253);
                if (pattern == PAT_MIXED)
                    case ($urandom_range(0, 3))
                        0:       pat = PAT_RANDOM;
                        3:       pat = PAT_EXTREME;
                        default: pat = PAT_BAND;
                    endcase
                first = (pos == 0) ? !resume : ($urandom_range(0, 4) != 0);
            end
            else if (noisy)
                first = ($urandom_range(0, 199) == 0);
            r = (pos / w) % h;
            c = pos % w;
            case (pat)
                PAT_BAND:       pix = PIX_W'(base - 2 + $urandom_range(0, 4));
                PAT_EXTREME:    pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                PAT_CENTRE_MAX: pix = (r == CENTRE_ROW_OFF && c == CENTRE_COL_OFF) ? 8'hFF : 8'h00;
                PAT_CENTRE_MIN: pix = (r == CENTRE_ROW_OFF && c == CENTRE_COL_OFF) ? 8'h00 : 8'hFF;
                PAT_FLAT:       pix = PIX_W'(base);
                PAT_NEAR:       pix = (r == CENTRE_ROW_OFF && c == CENTRE_COL_OFF) ?
                                      8'd128 : PIX_W'($urandom_range(127, 129));
                default:        pix = PIX_W'($urandom_range(0, 255));
            endcase
            send_pixel(pix, first);
            if (pos + 1 == hold_at)
            begin
                s_axis_tvalid <= 1'b0;
                drain();
            end
            else
                sender_gap();
        end
        s_axis_tvalid <= 1'b0;
        drain();
    endtask

    initial
    begin : stimulus
        logic [FH_W-1:0] w_raw;
        logic [FH_W-1:0] h_raw;
        int unsigned     prev_w;
        int unsigned     sel;
        bit              resume;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_FRAME_WIDTH;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        idle_on = 1'b1;
        cycle_count = 0;
        pixels_in = 0;
        settings_used = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset frame size: first row only, no descriptors due yet
        run_phase('0, '0, 0, 100, 0, 0, PAT_RANDOM, 0);

        // 9x7 frames, one descriptor each; sizes below minimum saturate
        run_phase(13'd0, 13'd3, 1, 63, 0, 0, PAT_CENTRE_MAX, 0);
        run_phase('0, '0, 0, 63, 1, 0, PAT_CENTRE_MIN, 0);
        run_phase('0, '0, 0, 63, 0, 0, PAT_FLAT, 0);
        run_phase('0, '0, 0, 63, 1, 0, PAT_NEAR, 0);
        run_phase('0, '0, 0, 63, 0, 0, PAT_EXTREME, 0);
        run_phase(13'd9, 13'd7, 1, 189, 0, 1, PAT_MIXED, 0);

        // stop mid-frame, then shrink width and later height without a frame start
        run_phase(13'd20, 13'd12, 1, 9 * 20 + 15, 0, 0, PAT_RANDOM, 0);
        run_phase(13'd10, 13'd12, 1, 115, 1, 0, PAT_RANDOM, 0);
        run_phase(13'd10, 13'd8, 1, 200, 1, 1, PAT_MIXED, 100);

        // widest and tallest frames, first rows only
        run_phase(13'd4095, 13'd0, 1, 100, 0, 0, PAT_MIXED, 0);
        run_phase(13'd3, 13'd8191, 1, 100, 0, 0, PAT_BAND, 0);

        prev_w = MIN_W;
        for (int i = 0; i < 3; i++)
        begin
            sel = $urandom_range(0, 9);
            w_raw = (sel == 0) ? FH_W'($urandom_range(0, MIN_W - 1)) :
                                 FH_W'($urandom_range(MIN_W, 16));
            if (sel == 1)
                h_raw = FH_W'($urandom_range(0, MIN_H - 1));
            else if (sel == 2)
                h_raw = FH_W'($urandom_range(MAX_H + 1, 8191));
            else
                h_raw = FH_W'($urandom_range(MIN_H, 14));
            resume = (clamp_width(w_raw[FW_W-1:0]) <= prev_w) && ($urandom_range(0, 1) == 1);
            idle_on = (i != 2);
            run_phase(w_raw, h_raw, 1, $urandom_range(100, 180), resume, 1, PAT_MIXED,
                      (i == 1) ? 80 : 0);
            prev_w = clamp_width(w_raw[FW_W-1:0]);
        end
        idle_on = 1'b1;

        drain();
        if (sb.pending_descriptors.size() != 0)
        begin
            $display("ERROR: %0d descriptors never arrived", sb.pending_descriptors.size());
            sb.faults += sb.pending_descriptors.size();
        end
        $display("Sent %0d pixels under %0d frame sizes, widths 9..2048 and heights 7..4096.",
                 pixels_in, settings_used + 1);
        $display("Checked %0d census descriptors, %0d faults.", sb.checked, sb.faults);
        if (sb.faults == 0)
            $display("census_transform_9x7_top test passed");
        else
            $display("census_transform_9x7_top test failed");
        $finish;
    end

endmodule
